[rtl/core/bitmap_page_allocator_assert.svh]
// Assertion macros for the page allocator. Clock clk, reset arst_n.
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BAP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define BAP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define BAP_ASSERT(label, prop, msg)
`define BAP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/core/bap_pkg.sv]
`timescale 1ns / 1ps
package bap_pkg;

	localparam int MAX_PAGES_DEF = 32768;
	localparam int WORD_BITS_DEF = 32;
	localparam int PAGE_W        = 15;
	localparam int CNT_W         = 16;

	localparam logic [CNT_W-1:0] TOTAL_RST = 16'd32768;
	localparam logic [CNT_W-1:0] USED_RST  = 16'd32768;

	typedef enum logic [1:0] {
		OP_MARK_ALL = 2'd0,
		OP_ALLOC    = 2'd1,
		OP_FREE     = 2'd2,
		OP_RESERVE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_OOM          = 3'd1,
		ST_INVALID      = 3'd2,
		ST_DOUBLE_FREE  = 3'd3,
		ST_ALREADY_USED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_FILL,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_LOOKUP,
		S_MODIFY
	} state_t;

	typedef struct packed {
		op_t               operation;
		logic [PAGE_W-1:0] page_index;
	} req_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page_number;
		status_t           status;
		logic [CNT_W-1:0]  used_pages;
		logic [CNT_W-1:0]  free_pages;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic fill;
		logic mark_done;
		logic scan_rd;
		logic scan_chk;
		logic oom;
		logic lookup;
		logic modify;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic fill_last;
		logic scan_end;
		logic found;
	} dp_sts_t;

endpackage

[rtl/core/bap_ctrl.sv]
`timescale 1ns / 1ps
module bap_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bap_pkg::op_t     operation,
	input  bap_pkg::dp_sts_t sts,
	output logic             busy,
	output bap_pkg::dp_cmd_t cmd
);
	import bap_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (sts.fill_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					case (operation)
						OP_MARK_ALL: state_d = S_FILL;
						OP_ALLOC:    state_d = S_SCAN_RD;
						default:     state_d = S_LOOKUP;
					endcase
				end
			end
			S_FILL: begin
				if (sts.fill_last) state_d = S_IDLE;
			end
			S_SCAN_RD: begin
				state_d = sts.scan_end ? S_IDLE : S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				state_d = sts.found ? S_IDLE : S_SCAN_RD;
			end
			S_LOOKUP: state_d = S_MODIFY;
			S_MODIFY: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			S_INIT: cmd.fill = 1'b1;
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_FILL: begin
				cmd.fill      = 1'b1;
				cmd.mark_done = sts.fill_last;
			end
			S_SCAN_RD: begin
				cmd.scan_rd = !sts.scan_end;
				cmd.oom     = sts.scan_end;
			end
			S_SCAN_CHK: cmd.scan_chk = 1'b1;
			S_LOOKUP:   cmd.lookup   = 1'b1;
			S_MODIFY:   cmd.modify   = 1'b1;
			default:    busy = 1'b1;
		endcase
	end

endmodule

[rtl/core/bap_dp.sv]
`timescale 1ns / 1ps
module bap_dp #(
	parameter int MAX_PAGES = bap_pkg::MAX_PAGES_DEF,
	parameter int WORD_BITS = bap_pkg::WORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bap_pkg::req_t             req,
	input  logic [bap_pkg::CNT_W-1:0] total_pages,
	input  bap_pkg::dp_cmd_t          cmd,
	output bap_pkg::dp_sts_t          sts,
	output logic                      done,
	output bap_pkg::rsp_t             rsp
);
	import bap_pkg::*;

	localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BTW       = $clog2(WORD_BITS);
	localparam int SPAN_W    = $clog2(MAP_WORDS * WORD_BITS + 1);
	localparam int CW        = (SPAN_W > CNT_W + 1) ? SPAN_W : CNT_W + 1;
	// page / WORD_BITS as multiply by a rounded-up reciprocal, exact for PAGE_W-bit pages
	localparam int DIV_K     = PAGE_W + BTW;
	localparam longint unsigned RECIP =
		((64'd1 << DIV_K) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS);
	localparam int RW        = $clog2(RECIP + 1);
	localparam int PROD_W    = PAGE_W + RW;
	localparam int XW        = (AW > PAGE_W) ? AW : PAGE_W;

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rdata_q;

	op_t               op_q;
	logic [PAGE_W-1:0] page_q;
	logic [AW-1:0]     word_q;
	logic [BTW-1:0]    bit_q;
	logic [AW-1:0]     scan_addr_q;
	logic [CW-1:0]     base_q;
	logic [CNT_W-1:0]  used_q;
	logic              done_q;
	rsp_t              rsp_q;

	logic [PROD_W-1:0] prod;
	logic [XW-1:0]     quot;
	logic [CW-1:0]     word_base;
	logic [CNT_W-1:0]  eff_total;
	logic [CW-1:0]     total_x;
	logic [CW-1:0]     remaining;
	logic [WORD_BITS-1:0] avail_mask;
	logic [WORD_BITS-1:0] free_v;
	logic [WORD_BITS-1:0] lsb_v;
	logic [BTW-1:0]    hit_idx;
	logic              found;
	logic [WORD_BITS-1:0] bit_mask;
	logic              bit_v;
	logic              in_range;
	logic              mod_set;
	logic              mod_clr;
	status_t           mod_status;
	logic [CNT_W-1:0]  used_inc;
	logic [CNT_W-1:0]  used_dec;
	logic [CNT_W-1:0]  used_n;
	logic              emit;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [WORD_BITS-1:0] wdata;
	logic              re;
	logic [AW-1:0]     raddr;

	assign eff_total = (32'(total_pages) < 32'(MAX_PAGES)) ? total_pages : CNT_W'(MAX_PAGES);
	assign total_x   = CW'(eff_total);

	// word index of the requested page
	assign prod      = PROD_W'(req.page_index) * PROD_W'(RECIP);
	assign quot      = XW'(prod >> DIV_K);
	assign word_base = CW'(word_q) * CW'(WORD_BITS);

	// scan: lowest free bit of the current word below the page limit
	assign remaining = total_x - base_q;
	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			avail_mask[i] = (CW'(i) < remaining);
		end
	end
	assign free_v = ~rdata_q & avail_mask;
	assign lsb_v  = free_v & (~free_v + WORD_BITS'(1));
	assign found  = |free_v;
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lsb_v[i]) hit_idx = hit_idx | BTW'(i);
		end
	end

	// single-page check for free / reserve
	assign bit_mask = WORD_BITS'(1) << bit_q;
	assign bit_v    = rdata_q[bit_q];
	assign in_range = CW'(page_q) < total_x;
	always_comb begin
		mod_set    = 1'b0;
		mod_clr    = 1'b0;
		mod_status = ST_OK;
		case (op_q)
			OP_FREE: begin
				if (page_q == '0) begin
					mod_status = ST_OK;
				end else if (!in_range) begin
					mod_status = ST_INVALID;
				end else if (!bit_v) begin
					mod_status = ST_DOUBLE_FREE;
				end else begin
					mod_clr = 1'b1;
				end
			end
			OP_RESERVE: begin
				if (!in_range) begin
					mod_status = ST_INVALID;
				end else if (bit_v) begin
					mod_status = ST_ALREADY_USED;
				end else begin
					mod_set = 1'b1;
				end
			end
			default: mod_status = ST_OK;
		endcase
	end

	// saturating used counter
	assign used_inc = (used_q != '1) ? used_q + CNT_W'(1) : used_q;
	assign used_dec = (used_q != '0) ? used_q - CNT_W'(1) : used_q;
	always_comb begin
		used_n = used_q;
		if (cmd.mark_done) begin
			used_n = eff_total;
		end else if ((cmd.scan_chk && found) || (cmd.modify && mod_set)) begin
			used_n = used_inc;
		end else if (cmd.modify && mod_clr) begin
			used_n = used_dec;
		end
	end

	// memory ports
	assign re    = cmd.scan_rd || cmd.lookup;
	assign raddr = cmd.lookup ? word_q : scan_addr_q;
	always_comb begin
		we    = 1'b0;
		waddr = scan_addr_q;
		wdata = '1;
		if (cmd.fill) begin
			we = 1'b1;
		end else if (cmd.scan_chk) begin
			we    = found;
			wdata = rdata_q | lsb_v;
		end else if (cmd.modify) begin
			we    = mod_set || mod_clr;
			waddr = word_q;
			wdata = mod_set ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	assign emit = cmd.mark_done || cmd.oom || (cmd.scan_chk && found) || cmd.modify;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			base_q      <= '0;
			used_q      <= USED_RST;
			done_q      <= 1'b0;
		end else begin
			done_q <= emit;
			used_q <= used_n;
			if (cmd.load) begin
				scan_addr_q <= '0;
				base_q      <= '0;
			end else if (cmd.fill) begin
				scan_addr_q <= sts.fill_last ? '0 : scan_addr_q + AW'(1);
			end else if (cmd.scan_chk && !found) begin
				scan_addr_q <= scan_addr_q + AW'(1);
				base_q      <= base_q + CW'(WORD_BITS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req.operation;
			page_q <= req.page_index;
			word_q <= quot[AW-1:0];
		end
		if (cmd.lookup) begin
			bit_q <= BTW'(CW'(page_q) - word_base);
		end
		if (emit) begin
			rsp_q.used_pages <= used_n;
			rsp_q.free_pages <= (used_n <= eff_total) ? eff_total - used_n : '0;
			if (cmd.oom) begin
				rsp_q.page_number <= '0;
				rsp_q.status      <= ST_OOM;
			end else if (cmd.scan_chk) begin
				rsp_q.page_number <= PAGE_W'(base_q + CW'(hit_idx));
				rsp_q.status      <= ST_OK;
			end else if (cmd.modify) begin
				rsp_q.page_number <= page_q;
				rsp_q.status      <= mod_status;
			end else begin
				rsp_q.page_number <= page_q;
				rsp_q.status      <= ST_OK;
			end
		end
	end

	assign sts.fill_last = (scan_addr_q == AW'(MAP_WORDS - 1));
	assign sts.scan_end  = (base_q >= total_x);
	assign sts.found     = found;
	assign done          = done_q;
	assign rsp           = rsp_q;

endmodule

[rtl/core/bitmap_page_allocator.sv]
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// --------  -------------------  -----------------------------------------------
// request   start / busy         req  : operation, page_index
// result    done (1-cycle pulse) rsp  : page_number, status, used_pages, free_pages
// config    cfg_valid/cfg_ready  cfg_data : total_pages
//
// One item at a time, taken when start is high and busy is low; its result sits on rsp
// for the one cycle that done is high, the first cycle with busy low again.
// free / reserve: a word read, then a read-modify-write; mark_all_used: one word
// written per cycle over all MAP_WORDS words; alloc: each word up to the hit is read,
// then checked (one read port), out of memory once the scan passes total. After reset
// a clearing pass sets all MAP_WORDS words, busy high; done cannot be held off.
`include "bitmap_page_allocator_assert.svh"
module bitmap_page_allocator #(
	parameter int MAX_PAGES = bap_pkg::MAX_PAGES_DEF,
	parameter int WORD_BITS = bap_pkg::WORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request item
	input  logic                      start,
	output logic                      busy,
	input  bap_pkg::req_t             req,
	// result item
	output logic                      done,
	output bap_pkg::rsp_t             rsp,
	// total_pages write
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bap_pkg::CNT_W-1:0] cfg_data
);
	import bap_pkg::*;

	logic [CNT_W-1:0] total_pages_q;
	dp_cmd_t          cmd;
	dp_sts_t          sts;

	// Config is always accepted; it is only meant to change while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_pages_q <= TOTAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			total_pages_q <= cfg_data;
		end
	end

	// sequencer: clearing pass, fill sweep, word scan, read-modify-write
	bap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (req.operation),
		.sts       (sts),
		.busy      (busy),
		.cmd       (cmd)
	);

	// bitmap memory, used counter and result register
	bap_dp #(
		.MAX_PAGES (MAX_PAGES),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.total_pages (total_pages_q),
		.cmd         (cmd),
		.sts         (sts),
		.done        (done),
		.rsp         (rsp)
	);

	// a result always closes a busy period
	`BAP_ASSERT(a_done_after_busy, !done || $past(busy), "result without a busy cycle")
	// no result in the cycle right after an item is taken
	`BAP_ASSERT_NEXT(a_no_early_result, start && !busy, !done, "result too early")
	// at most one source drives the bitmap write port
	`BAP_ASSERT(a_one_writer, $onehot0({cmd.fill, cmd.scan_chk, cmd.modify}), "write clash")
	// out of memory always reports page zero
	`BAP_ASSERT(a_oom_page_zero, !done || rsp.status != ST_OOM || rsp.page_number == '0,
		"out of memory with nonzero page")

endmodule

[tb/tb_bitmap_page_allocator.sv]
`timescale 1ns / 1ps
// Self-checking bench for the bitmap page allocator. One item in flight at a time:
// start/busy request, done-pulse result, valid/ready write of total_pages.
module tb_bitmap_page_allocator;
	import bap_pkg::*;

	localparam int MAP_WORDS = MAX_PAGES_DEF / WORD_BITS_DEF;
	// worst single item is an out-of-memory scan at full size
	localparam int TAIL_CYCLES = 2 * MAP_WORDS + 64;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	// Directed row: an item (with an optional hand-written expectation) or a
	// total_pages write taken while the block is idle.
	typedef struct packed {
		row_kind_t         kind;
		op_t               op;
		logic [PAGE_W-1:0] page;
		logic [CNT_W-1:0]  total;
		logic              typed;
		rsp_t              want;
	} dir_row_t;

	typedef struct packed {
		logic [CNT_W-1:0] total;
		logic [7:0]       idle_pct;
		logic [15:0]      count;
	} phase_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req;
	logic             done;
	rsp_t             rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	// shadow of the block: bitmap, used counter, register
	logic [WORD_BITS_DEF-1:0] page_map [MAP_WORDS];
	logic [CNT_W-1:0]         used_cnt;
	logic [CNT_W-1:0]         total_pages_cfg;

	rsp_t              pending_rsp[$];
	logic [PAGE_W-1:0] granted[$];     // pages this bench believes it holds
	logic              row_typed;
	rsp_t              row_exp;
	int unsigned       idle_pct;
	int unsigned       items_taken;
	int unsigned       cfg_writes;
	int unsigned       err_count;
	int unsigned       grants;
	int unsigned       oom_hits;
	int unsigned       rejects;

	// Directed part. The opening rows run at the full size straight out of reset,
	// so every page is used: out of memory, null free, a free / double free / realloc
	// of the top page. Then the range checks at a small size, mark-all, the empty
	// configuration, counter saturation at zero and an oversized register value.
	dir_row_t dir_rows [31] = '{
		'{ROW_CFG,  OP_MARK_ALL, 15'd0,     16'd32768, 1'b0, '0},
		'{ROW_ITEM, OP_ALLOC,    15'd0,     16'd0, 1'b1,
			'{15'd0, ST_OOM, 16'd32768, 16'd0}},
		'{ROW_ITEM, OP_FREE,     15'd0,     16'd0, 1'b1,
			'{15'd0, ST_OK, 16'd32768, 16'd0}},
		'{ROW_ITEM, OP_FREE,     15'd32767, 16'd0, 1'b1,
			'{15'd32767, ST_OK, 16'd32767, 16'd1}},
		'{ROW_ITEM, OP_FREE,     15'd32767, 16'd0, 1'b1,
			'{15'd32767, ST_DOUBLE_FREE, 16'd32767, 16'd1}},
		'{ROW_ITEM, OP_ALLOC,    15'd0,     16'd0, 1'b1,
			'{15'd32767, ST_OK, 16'd32768, 16'd0}},
		'{ROW_ITEM, OP_RESERVE,  15'd32767, 16'd0, 1'b1,
			'{15'd32767, ST_ALREADY_USED, 16'd32768, 16'd0}},
		'{ROW_CFG,  OP_MARK_ALL, 15'd0,     16'd64, 1'b0, '0},
		'{ROW_ITEM, OP_FREE,     15'd64,    16'd0, 1'b1,
			'{15'd64, ST_INVALID, 16'd32768, 16'd0}},
		'{ROW_ITEM, OP_RESERVE,  15'd64,    16'd0, 1'b1,
			'{15'd64, ST_INVALID, 16'd32768, 16'd0}},
		'{ROW_ITEM, OP_FREE,     15'd63,    16'd0, 1'b1,
			'{15'd63, ST_OK, 16'd32767, 16'd0}},
		'{ROW_ITEM, OP_RESERVE,  15'd63,    16'd0, 1'b1,
			'{15'd63, ST_OK, 16'd32768, 16'd0}},
		'{ROW_ITEM, OP_FREE,     15'd1,     16'd0, 1'b1,
			'{15'd1, ST_OK, 16'd32767, 16'd0}},
		'{ROW_ITEM, OP_ALLOC,    15'd0,     16'd0, 1'b1,
			'{15'd1, ST_OK, 16'd32768, 16'd0}},
		'{ROW_ITEM, OP_MARK_ALL, 15'h7fff,  16'd0, 1'b1,
			'{15'h7fff, ST_OK, 16'd64, 16'd0}},
		'{ROW_ITEM, OP_FREE,     15'd5,     16'd0, 1'b1,
			'{15'd5, ST_OK, 16'd63, 16'd1}},
		'{ROW_ITEM, OP_ALLOC,    15'h1234,  16'd0, 1'b1,
			'{15'd5, ST_OK, 16'd64, 16'd0}},
		'{ROW_ITEM, OP_ALLOC,    15'd0,     16'd0, 1'b1,
			'{15'd0, ST_OOM, 16'd64, 16'd0}},
		'{ROW_CFG,  OP_MARK_ALL, 15'd0,     16'd0, 1'b0, '0},
		'{ROW_ITEM, OP_MARK_ALL, 15'h2aaa,  16'd0, 1'b1,
			'{15'h2aaa, ST_OK, 16'd0, 16'd0}},
		'{ROW_ITEM, OP_ALLOC,    15'd0,     16'd0, 1'b1,
			'{15'd0, ST_OOM, 16'd0, 16'd0}},
		'{ROW_ITEM, OP_RESERVE,  15'd0,     16'd0, 1'b1,
			'{15'd0, ST_INVALID, 16'd0, 16'd0}},
		'{ROW_ITEM, OP_FREE,     15'd0,     16'd0, 1'b1,
			'{15'd0, ST_OK, 16'd0, 16'd0}},
		'{ROW_CFG,  OP_MARK_ALL, 15'd0,     16'hffff, 1'b0, '0},
		// counter is already zero: the free clears the bit but the count holds
		'{ROW_ITEM, OP_FREE,     15'd100,   16'd0, 1'b1,
			'{15'd100, ST_OK, 16'd0, 16'd32768}},
		'{ROW_ITEM, OP_FREE,     15'h5555,  16'd0, 1'b0, '0},
		'{ROW_ITEM, OP_ALLOC,    15'd0,     16'd0, 1'b0, '0},
		'{ROW_ITEM, OP_RESERVE,  15'h5555,  16'd0, 1'b0, '0},
		'{ROW_CFG,  OP_MARK_ALL, 15'd0,     16'd1, 1'b0, '0},
		'{ROW_ITEM, OP_ALLOC,    15'd0,     16'd0, 1'b1,
			'{15'd0, ST_OOM, 16'd2, 16'd0}},
		'{ROW_ITEM, OP_FREE,     15'd0,     16'd0, 1'b1,
			'{15'd0, ST_OK, 16'd2, 16'd0}}
	};

	// Random phases: mostly small sizes; the full-size ones are short since an
	// alloc there may scan the whole map.
	phase_t phases [11] = '{
		'{16'd64,    8'd0,  16'd200},
		'{16'd200,   8'd84, 16'd150},
		'{16'd1,     8'd16, 16'd40},
		'{16'd1000,  8'd0,  16'd150},
		'{16'd32768, 8'd84, 16'd70},
		'{16'd33,    8'd16, 16'd150},
		'{16'd0,     8'd0,  16'd30},
		'{16'hffff,  8'd16, 16'd60},
		'{16'd96,    8'd84, 16'd180},
		'{16'd40000, 8'd0,  16'd50},
		'{16'd128,   8'd16, 16'd150}
	};

	bitmap_page_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Page count actually managed for a given register value.
	function automatic int unsigned managed_pages(input logic [CNT_W-1:0] total);
		return (total < MAX_PAGES_DEF) ? int'(total) : MAX_PAGES_DEF;
	endfunction

	// Applies one item to the shadow bitmap and returns the result it must produce.
	function automatic rsp_t apply_page_op(input req_t r);
		int unsigned lim;
		int unsigned nwords;
		int unsigned w;
		int unsigned b;
		int unsigned p;
		int unsigned pg;
		bit          hit;
		rsp_t        res;
		lim = managed_pages(total_pages_cfg);
		pg = r.page_index;
		p = 0;
		hit = 1'b0;
		res.page_number = r.page_index;
		res.status = ST_OK;
		case (r.operation)
		OP_MARK_ALL: begin
			for (w = 0; w < MAP_WORDS; w++)
				page_map[w] = '1;
			used_cnt = lim[CNT_W-1:0];
		end
		OP_ALLOC: begin
			// first fit: full words are skipped, only pages below the size count
			nwords = (lim + WORD_BITS_DEF - 1) / WORD_BITS_DEF;
			for (w = 0; w < nwords && !hit; w++) begin
				if (page_map[w] != '1) begin
					for (b = 0; b < WORD_BITS_DEF && !hit; b++) begin
						p = w * WORD_BITS_DEF + b;
						if (p < lim && !page_map[w][b])
							hit = 1'b1;
					end
				end
			end
			if (hit) begin
				page_map[p / WORD_BITS_DEF][p % WORD_BITS_DEF] = 1'b1;
				res.page_number = p[PAGE_W-1:0];
				if (used_cnt != '1)
					used_cnt++;
			end else begin
				res.status = ST_OOM;
				res.page_number = '0;
			end
		end
		OP_FREE: begin
			// page zero is the null address and is silently ignored
			if (pg != 0) begin
				if (pg >= lim)
					res.status = ST_INVALID;
				else if (!page_map[pg / WORD_BITS_DEF][pg % WORD_BITS_DEF])
					res.status = ST_DOUBLE_FREE;
				else begin
					page_map[pg / WORD_BITS_DEF][pg % WORD_BITS_DEF] = 1'b0;
					if (used_cnt != '0)
						used_cnt--;
				end
			end
		end
		default: begin
			if (pg >= lim)
				res.status = ST_INVALID;
			else if (page_map[pg / WORD_BITS_DEF][pg % WORD_BITS_DEF])
				res.status = ST_ALREADY_USED;
			else begin
				page_map[pg / WORD_BITS_DEF][pg % WORD_BITS_DEF] = 1'b1;
				if (used_cnt != '1)
					used_cnt++;
			end
		end
		endcase
		res.used_pages = used_cnt;
		// the counter can drift past the size after a register change
		res.free_pages = (used_cnt <= lim) ? CNT_W'(lim - used_cnt) : '0;
		return res;
	endfunction

	// Observation at the rising edge: results first, then the taken item.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		rsp_t predicted;
		if (arst_n) begin
			if (done) begin
				if (pending_rsp.size() == 0) begin
					$error("result with no item outstanding: page_number %0d status %0d",
						rsp.page_number, rsp.status);
					err_count++;
				end else begin
					exp_rsp = pending_rsp.pop_front();
					if (rsp.page_number !== exp_rsp.page_number) begin
						$error("page_number: expected %0d, got %0d",
							exp_rsp.page_number, rsp.page_number);
						err_count++;
					end
					if (rsp.status !== exp_rsp.status) begin
						$error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
						err_count++;
					end
					if (rsp.used_pages !== exp_rsp.used_pages) begin
						$error("used_pages: expected %0d, got %0d",
							exp_rsp.used_pages, rsp.used_pages);
						err_count++;
					end
					if (rsp.free_pages !== exp_rsp.free_pages) begin
						$error("free_pages: expected %0d, got %0d",
							exp_rsp.free_pages, rsp.free_pages);
						err_count++;
					end
				end
			end
			if (start && !busy) begin
				predicted = apply_page_op(req);
				pending_rsp.push_back(row_typed ? row_exp : predicted);
				items_taken++;
				if (predicted.status == ST_OK &&
						(req.operation == OP_ALLOC || req.operation == OP_RESERVE))
					granted.push_back(predicted.page_number);
				if (req.operation == OP_ALLOC && predicted.status == ST_OK)
					grants++;
				if (predicted.status == ST_OOM)
					oom_hits++;
				if (predicted.status == ST_INVALID || predicted.status == ST_DOUBLE_FREE ||
						predicted.status == ST_ALREADY_USED)
					rejects++;
			end
			if (cfg_valid && cfg_ready) begin
				total_pages_cfg = cfg_data;
				cfg_writes++;
			end
		end
	end

	// Offers one item from a falling edge and returns at the falling edge after it
	// was taken. start stays high across back-to-back items.
	task automatic issue_item(input req_t r, input logic typed, input rsp_t want);
		int unsigned seen;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		seen = items_taken;
		req <= r;
		row_typed <= typed;
		row_exp <= want;
		start <= 1'b1;
		do
			@(negedge clk);
		while (items_taken == seen);
	endtask

	// Holds the request side off until every outstanding result is back.
	task automatic wait_results();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending_rsp.size() != 0);
	endtask

	task automatic write_total(input logic [CNT_W-1:0] value);
		int unsigned seen;
		seen = cfg_writes;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do
			@(negedge clk);
		while (cfg_writes == seen);
		cfg_valid <= 1'b0;
	endtask

	// Random item: mostly alloc and free of held pages, with in-range reserves,
	// noise frees/reserves anywhere, boundary pages and a rare mark-all.
	function automatic req_t draw_item(input int unsigned lim);
		int unsigned pick;
		int unsigned k;
		int unsigned edge_pg;
		req_t        r;
		pick = $urandom_range(99);
		r.page_index = PAGE_W'($urandom_range(32767));
		r.operation = OP_ALLOC;
		if (pick < 2)
			r.operation = OP_MARK_ALL;
		else if (pick < 34)
			r.operation = OP_ALLOC;
		else if (pick < 66) begin
			r.operation = OP_FREE;
			if (granted.size() != 0) begin
				k = $urandom_range(granted.size() - 1);
				r.page_index = granted[k];
				granted.delete(k);
			end else if (lim != 0)
				r.page_index = PAGE_W'($urandom_range(lim - 1));
		end else if (pick < 78) begin
			r.operation = OP_RESERVE;
			if (lim != 0)
				r.page_index = PAGE_W'($urandom_range(lim - 1));
		end else if (pick < 88)
			r.operation = OP_FREE;
		else if (pick < 94)
			r.operation = OP_RESERVE;
		else begin
			// just inside or just past the last managed page
			r.operation = (pick % 2) ? OP_FREE : OP_RESERVE;
			edge_pg = (lim == 0) ? 0 : lim - $urandom_range(1);
			if (edge_pg > 32767)
				edge_pg = 32767;
			r.page_index = edge_pg[PAGE_W-1:0];
		end
		return r;
	endfunction

	initial begin
		req_t r;
		for (int w = 0; w < MAP_WORDS; w++)
			page_map[w] = '1;
		used_cnt = USED_RST;
		total_pages_cfg = TOTAL_RST;
		items_taken = 0;
		cfg_writes = 0;
		err_count = 0;
		grants = 0;
		oom_hits = 0;
		rejects = 0;
		idle_pct = 16;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		row_typed = 1'b0;
		row_exp = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		clk = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// the block sits in its clearing pass here; items simply wait on busy
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_results();
				write_total(dir_rows[i].total);
			end else begin
				r.operation = dir_rows[i].op;
				r.page_index = dir_rows[i].page;
				issue_item(r, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		foreach (phases[i]) begin
			wait_results();
			write_total(phases[i].total);
			granted.delete();
			idle_pct = phases[i].idle_pct;
			repeat (phases[i].count) begin
				// now and then let the block drain completely before the next item
				if ($urandom_range(199) == 0)
					wait_results();
				issue_item(draw_item(managed_pages(phases[i].total)), 1'b0, '0);
			end
		end

		wait_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Ran %0d items across %0d total_pages writes, sizes 0 through 65535.",
			items_taken, cfg_writes);
		$display("Allocs granted %0d, out of memory %0d, frees/reserves rejected %0d.",
			grants, oom_hits, rejects);
		if (err_count == 0)
			$display("bitmap_page_allocator verification clean");
		else
			$display("bitmap_page_allocator verification failed");
		$finish;
	end

	// hang guard, several times the slowest legal run
	initial begin
		#400_000_000;
		$display("bitmap_page_allocator verification failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/bap_pkg.sv
rtl/core/bap_ctrl.sv
rtl/core/bap_dp.sv
rtl/core/bitmap_page_allocator.sv
tb/tb_bitmap_page_allocator.sv
